// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the downsampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, checked only outside reset.
`define GPD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gpd assertion failed");

// Concurrent assertion, checked on every edge including reset.
`define GPD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gpd assertion failed (reset check)");

`endif

// ===== hw/rtl/gpd_pkg.sv =====
// Types and constants shared by the Gaussian pyramid downsampler.
`timescale 1ns / 1ps
`default_nettype none

package gpd_pkg;

  // Frame size limits (output pixels)
  localparam int MAX_OUT_WIDTH  = 1024;
  localparam int MAX_OUT_HEIGHT = 1024;

  // Field widths
  localparam int PIX_W       = 8;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int DIM_W       = 11;
  localparam int FR_W        = 10;
  localparam int POS_W       = 11;
  localparam int SUM_W       = 12;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_TDATA_W = 32;

  // Line store: four row slots, one bank each
  localparam int N_SLOTS   = 4;
  localparam int SLOT_W    = 2;
  localparam int LS_DEPTH  = MAX_OUT_WIDTH;
  localparam int LS_ADDR_W = $clog2(LS_DEPTH);

  // Register reset values
  localparam logic [DIM_W-1:0] OUT_WIDTH_RST     = DIM_W'(320);
  localparam logic [DIM_W-1:0] OUT_HEIGHT_RST    = DIM_W'(240);
  localparam logic [FR_W-1:0]  FIRST_OUT_ROW_RST = FR_W'(80);

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OUT_WIDTH     = 2'd0,
    REG_OUT_HEIGHT    = 2'd1,
    REG_FIRST_OUT_ROW = 2'd2
  } cfg_reg_t;

  // Per-pixel decision from the front end, valid with an input transaction
  typedef struct packed {
    logic              have;       // horizontal sample produced, write line store
    logic              emit_v;     // vertically filtered result for this pixel
    logic              emit_last;  // last-row copy result for this pixel
    logic [SLOT_W-1:0] slot;       // source row mod 4
    logic [COL_W-1:0]  j;          // line store column
    logic [PIX_W-1:0]  f;          // horizontal filter result
    logic [PIX_W-1:0]  pix;        // raw source pixel
    logic [COL_W-1:0]  col;        // output column
    logic [ROW_W-1:0]  row;        // output row
    logic              frame_end;  // last pixel of the frame
  } front_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gpd_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
`timescale 1ns / 1ps
`default_nettype none

module gpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read sees the old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpd_front.sv =====
// Source position tracking and horizontal 1-4-6-4-1 filter.
`timescale 1ns / 1ps
`default_nettype none

module gpd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_fire,
  input  wire logic [gpd_pkg::PIX_W-1:0]   pixel,
  input  wire logic [gpd_pkg::DIM_W-1:0]   out_width,
  input  wire logic [gpd_pkg::DIM_W-1:0]   out_height,
  input  wire logic [gpd_pkg::FR_W-1:0]    first_out_row,
  output gpd_pkg::front_t                  fo
);

  import gpd_pkg::*;

  localparam logic [DIM_W-1:0] MAX_W_C = DIM_W'(MAX_OUT_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_C = DIM_W'(MAX_OUT_HEIGHT);
  localparam logic [DIM_W-1:0] MIN_C   = DIM_W'(2);

  logic [PIX_W-1:0] hwin [4];
  logic [POS_W-1:0] src_col;
  logic [POS_W-1:0] src_row;
  logic [POS_W-1:0] src_col_next;
  logic [POS_W-1:0] src_row_next;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [FR_W-1:0]  fr;
  logic [DIM_W-1:0] wm1;
  logic [DIM_W-1:0] hm1;
  logic [POS_W:0]   two_w;
  logic [POS_W:0]   two_h;
  logic             col_wrap;
  logic [POS_W:0]   row_pre;
  logic [POS_W-1:0] c;
  logic [POS_W-1:0] r;
  logic [POS_W:0]   c_inc;
  logic [POS_W:0]   r_inc;
  logic [SUM_W-1:0] hsum;
  logic             hv;
  logic             last_col;
  logic [COL_W-1:0] j_h;
  logic [COL_W-1:0] j;
  logic [PIX_W-1:0] f;
  logic [ROW_W-1:0] i;
  logic             row_ok;

  // Clamp the size registers and the first row
  always_comb begin
    if (out_width < MIN_C) begin
      w = MIN_C;
    end else if (out_width > MAX_W_C) begin
      w = MAX_W_C;
    end else begin
      w = out_width;
    end
    if (out_height < MIN_C) begin
      h = MIN_C;
    end else if (out_height > MAX_H_C) begin
      h = MAX_H_C;
    end else begin
      h = out_height;
    end
    fr    = (first_out_row == '0) ? FR_W'(1) : first_out_row;
    wm1   = w - DIM_W'(1);
    hm1   = h - DIM_W'(1);
    two_w = {w, 1'b0};
    two_h = {h, 1'b0};
  end

  // Effective position: wrap a position left beyond a smaller frame size
  always_comb begin
    col_wrap = {1'b0, src_col} >= two_w;
    row_pre  = col_wrap ? ({1'b0, src_row} + (POS_W + 1)'(1)) : {1'b0, src_row};
    c        = col_wrap ? '0 : src_col;
    r        = (row_pre >= two_h) ? '0 : row_pre[POS_W-1:0];
  end

  // Next position after this pixel
  always_comb begin
    c_inc = {1'b0, c} + (POS_W + 1)'(1);
    r_inc = {1'b0, r} + (POS_W + 1)'(1);
    if (c_inc >= two_w) begin
      src_col_next = '0;
      src_row_next = (r_inc >= two_h) ? '0 : r_inc[POS_W-1:0];
    end else begin
      src_col_next = c_inc[POS_W-1:0];
      src_row_next = r;
    end
  end

  // Horizontal filter centered two pixels back: 1-4-6-4-1, >> 4
  always_comb begin
    hsum = {2'b00, hwin[1], 2'b00} + {3'b000, hwin[1], 1'b0}
         + {2'b00, hwin[0], 2'b00} + {2'b00, hwin[2], 2'b00}
         + {4'b0000, hwin[3]} + {4'b0000, pixel};
    hv       = !c[0] && (c != '0);
    last_col = ({1'b0, c} == (two_w - (POS_W + 1)'(1)));
    j_h      = c[POS_W-1:1] - COL_W'(1);
    if (hv) begin
      j = j_h;
      f = (j_h == '0) ? hwin[1] : hsum[SUM_W-1:4];
    end else begin
      j = wm1[COL_W-1:0];
      f = pixel;
    end
  end

  // Output decisions for this pixel
  always_comb begin
    i      = r[POS_W-1:1] - ROW_W'(1);
    row_ok = !r[0] && (r != '0) && (i >= fr) && (({1'b0, i} + DIM_W'(2)) <= h);

    fo.have      = hv || last_col;
    fo.emit_v    = (hv || last_col) && row_ok;
    fo.emit_last = ({1'b0, r} == (two_h - (POS_W + 1)'(1))) && !c[0];
    fo.slot      = r[SLOT_W-1:0];
    fo.j         = j;
    fo.f         = f;
    fo.pix       = pixel;
    fo.col       = fo.emit_last ? c[POS_W-1:1] : j;
    fo.row       = fo.emit_last ? hm1[ROW_W-1:0] : i;
    fo.frame_end = fo.emit_last && (c[POS_W-1:1] == wm1[COL_W-1:0]);
  end

  // Pixel window and position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hwin[0] <= '0;
      hwin[1] <= '0;
      hwin[2] <= '0;
      hwin[3] <= '0;
      src_col <= '0;
      src_row <= '0;
    end else if (in_fire) begin
      hwin[3] <= hwin[2];
      hwin[2] <= hwin[1];
      hwin[1] <= hwin[0];
      hwin[0] <= pixel;
      src_col <= src_col_next;
      src_row <= src_row_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpd_vert.sv =====
// Line store banks, vertical 1-4-6-4-1 filter and output register.
`timescale 1ns / 1ps
`default_nettype none

module gpd_vert (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_fire,
  input  wire gpd_pkg::front_t           fo,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [gpd_pkg::PIX_W-1:0]      out_value,
  output logic [gpd_pkg::COL_W-1:0]      out_col,
  output logic [gpd_pkg::ROW_W-1:0]      out_row,
  output logic                           out_last
);

  import gpd_pkg::*;

  typedef struct packed {
    logic              is_last;
    logic [SLOT_W-1:0] slot;
    logic [PIX_W-1:0]  f;
    logic [PIX_W-1:0]  pix;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              frame_end;
  } stage_t;

  logic [PIX_W-1:0] rdata [N_SLOTS];
  logic             s1_valid;
  stage_t           s1;
  logic             adv;
  logic [PIX_W-1:0] ra;
  logic [PIX_W-1:0] rb;
  logic [PIX_W-1:0] rm;
  logic [PIX_W-1:0] rd;
  logic [SUM_W-1:0] vsum;
  logic [PIX_W-1:0] value;

  // One bank per row slot; all four are read at the same column
  for (genvar k = 0; k < N_SLOTS; k++) begin : g_bank
    gpd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LS_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (in_fire && fo.have && (fo.slot == SLOT_W'(k))),
      .waddr (fo.j[LS_ADDR_W-1:0]),
      .wdata (fo.f),
      .re    (in_fire && fo.emit_v),
      .raddr (fo.j[LS_ADDR_W-1:0]),
      .rdata (rdata[k])
    );
  end

  // Handshake: stage 1 moves when the output register is free or taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;

  // Stage 1 register, loaded with the result-bearing transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= fo.emit_v || fo.emit_last;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.is_last   <= fo.emit_last;
      s1.slot      <= fo.slot;
      s1.f         <= fo.f;
      s1.pix       <= fo.pix;
      s1.col       <= fo.col;
      s1.row       <= fo.row;
      s1.frame_end <= fo.frame_end;
    end
  end

  // Rows r-4, r-3, r-2, r-1 sit in slots r, r+1, r+2, r+3 (mod 4)
  always_comb begin
    ra    = rdata[s1.slot];
    rb    = rdata[s1.slot + SLOT_W'(1)];
    rm    = rdata[s1.slot + SLOT_W'(2)];
    rd    = rdata[s1.slot + SLOT_W'(3)];
    vsum  = {2'b00, rm, 2'b00} + {3'b000, rm, 1'b0}
          + {2'b00, rb, 2'b00} + {2'b00, rd, 2'b00}
          + {4'b0000, ra} + {4'b0000, s1.f};
    value = s1.is_last ? s1.pix : vsum[SUM_W-1:4];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_value <= value;
      out_col   <= s1.col;
      out_row   <= s1.row;
      out_last  <= s1.frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_pyramid_downsample.sv =====
// Top level of the 5x5 Gaussian pyramid 2:1 downsampler.
//
//   channel   dir  handshake                  contents
//   s_axis    in   s_axis_tvalid/tready       tdata[7:0] pixel
//   m_axis    out  m_axis_tvalid/tready       tdata value, out_col, out_row; tlast frame_end
//   cfg       in   cfg_we                     cfg_addr register index, cfg_wdata value
//
// One source pixel per clock while s_axis_tready is high. A result follows the
// transaction that causes it through the registered line store read and stage 1,
// then the output register. Reset is synchronous; it clears position, pixel window
// and valid flags and loads the register reset values. The line store is not cleared
// and needs no pass after reset. A stall on m_axis fills stage 1 and then drops s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_pyramid_downsample (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [gpd_pkg::PIX_W-1:0]         s_axis_tdata,   // [7:0] pixel
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] value, [17:8] out_col, [27:18] out_row, [31:28] zero
  output logic [gpd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast,   // frame_end
  input  wire logic                              cfg_we,
  input  wire logic [gpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [gpd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import gpd_pkg::*;

  logic [DIM_W-1:0] out_width;
  logic [DIM_W-1:0] out_height;
  logic [FR_W-1:0]  first_out_row;
  logic             in_fire;
  front_t           fo;
  logic [PIX_W-1:0] value;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_width     <= OUT_WIDTH_RST;
      out_height    <= OUT_HEIGHT_RST;
      first_out_row <= FIRST_OUT_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OUT_WIDTH:     out_width     <= cfg_wdata[DIM_W-1:0];
        REG_OUT_HEIGHT:    out_height    <= cfg_wdata[DIM_W-1:0];
        REG_FIRST_OUT_ROW: first_out_row <= cfg_wdata[FR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  gpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .pixel         (s_axis_tdata),
    .out_width     (out_width),
    .out_height    (out_height),
    .first_out_row (first_out_row),
    .fo            (fo)
  );

  gpd_vert u_vert (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .fo        (fo),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (value),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_last  (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {4'b0000, out_row, out_col, value};

endmodule

`default_nettype wire

// ===== hw/rtl/gpd_checker.sv =====
// Port-level assertions for the downsampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gpd_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [gpd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic                              m_axis_tlast
);

  // A stalled result keeps its contents
  `GPD_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // The input side is never held off while the output side takes results
  `GPD_ASSERT(a_no_input_stall, clk, rst, m_axis_tready |-> s_axis_tready)

  // A fresh result traces back to an input transaction through stage 1 and the output register
  `GPD_ASSERT(a_result_has_source, clk, rst, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))

  // Reset empties the output register
  `GPD_ASSERT_NR(a_reset_clears_out, clk, rst |=> !m_axis_tvalid)

endmodule

bind gaussian_pyramid_downsample gpd_checker u_gpd_checker (.*);

`default_nettype wire

// ===== test/gaussian_pyramid_downsample_tb.sv =====
// Self-checking stream testbench for the 5x5 Gaussian pyramid 2:1 downsampler.
`timescale 1ns / 1ps

module gaussian_pyramid_downsample_tb;
  import gpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned RANDOM_PIXELS = 500;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int COL_LO = PIX_W;
  localparam int ROW_LO = PIX_W + COL_W;
  localparam int PAD_LO = PIX_W + COL_W + ROW_W;

  // Source frame content patterns
  typedef enum int {
    PAT_RANDOM,
    PAT_WHITE,
    PAT_BLACK,
    PAT_CHECKER,
    PAT_RAMP
  } pix_pattern_t;

  // One downsampled output pixel
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } pyr_px_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;      // [7:0] pixel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [7:0] value, [17:8] out_col, [27:18] out_row
  logic                  m_axis_tlast;           // frame_end
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_addr = REG_OUT_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: registers, position, pixel window, filtered line copy
  logic [DIM_W-1:0] width_reg     = OUT_WIDTH_RST;
  logic [DIM_W-1:0] height_reg    = OUT_HEIGHT_RST;
  logic [FR_W-1:0]  first_row_reg = FIRST_OUT_ROW_RST;
  int unsigned      pos_col = 0;
  int unsigned      pos_row = 0;
  logic [PIX_W-1:0] row_window [4] = '{default: '0};
  logic [PIX_W-1:0] filtered_rows [N_SLOTS*MAX_OUT_WIDTH];

  pyr_px_t     pyramid_px_q[$];
  int unsigned mismatches   = 0;
  int unsigned pixels_sent  = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_max      = 13;
  int unsigned stall_max    = 13;
  int unsigned stall_left   = 0;

  gaussian_pyramid_downsample i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sizes as the block sees them, clamped to the supported range
  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_OUT_WIDTH) return MAX_OUT_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 2) return 2;
    if (height_reg > MAX_OUT_HEIGHT) return MAX_OUT_HEIGHT;
    return 32'(height_reg);
  endfunction

  // Filtered sample of source row r (mod 4) at output column j
  function automatic int unsigned stored(int unsigned r, int unsigned j);
    return 32'(filtered_rows[(r % N_SLOTS) * MAX_OUT_WIDTH + j]);
  endfunction

  // Advance the predictor by one source pixel, queue the output pixel it causes
  task automatic filter_and_decimate(input logic [PIX_W-1:0] pix);
    int unsigned w, h, fr, c, r, j, f, i, acc;
    bit have;
    pyr_px_t px;
    w = eff_width();
    h = eff_height();
    fr = (first_row_reg == 0) ? 1 : 32'(first_row_reg);
    have = 1'b0;
    j = 0;
    f = 0;
    if (pos_col >= 2 * w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= 2 * h) pos_row = 0;
    c = pos_col;
    r = pos_row;

    // horizontal 1-4-6-4-1 at even columns; edges copy the source pixel
    if (c % 2 == 0 && c >= 2) begin
      j = c / 2 - 1;
      if (j == 0)
        f = 32'(row_window[1]);
      else
        f = (6 * row_window[1] + 4 * (row_window[0] + row_window[2])
             + row_window[3] + pix) >> 4;
      have = 1'b1;
    end else if (c == 2 * w - 1) begin
      j = w - 1;
      f = 32'(pix);
      have = 1'b1;
    end

    // vertical pass over the four stored rows plus the current one
    if (have) begin
      if (r % 2 == 0 && r >= 2) begin
        i = r / 2 - 1;
        if (i >= fr && i + 2 <= h) begin
          acc = 6 * stored(r + 2, j) + 4 * (stored(r + 1, j) + stored(r + 3, j))
                + stored(r, j) + f;
          px.value     = PIX_W'(acc >> 4);
          px.col       = COL_W'(j);
          px.row       = ROW_W'(i);
          px.frame_end = 1'b0;
          pyramid_px_q.push_back(px);
        end
      end
      filtered_rows[(r % N_SLOTS) * MAX_OUT_WIDTH + j] = PIX_W'(f);
    end

    // last output row copies even pixels of the last source row
    if (r == 2 * h - 1 && c % 2 == 0) begin
      px.value     = pix;
      px.col       = COL_W'(c / 2);
      px.row       = ROW_W'(h - 1);
      px.frame_end = (c / 2 == w - 1);
      pyramid_px_q.push_back(px);
    end

    row_window[3] = row_window[2];
    row_window[2] = row_window[1];
    row_window[1] = row_window[0];
    row_window[0] = pix;

    pos_col++;
    if (pos_col >= 2 * w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= 2 * h) pos_row = 0;
    end
  endtask

  // Send one source pixel after a random gap; entered and left at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    filter_and_decimate(pix);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stop input, wait for every queued output pixel, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pyramid_px_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers while the block is idle at a frame boundary
  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, h, fr);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_OUT_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_addr  <= REG_OUT_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_addr  <= REG_FIRST_OUT_ROW;
    cfg_wdata <= fr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    width_reg     = w;
    height_reg    = h;
    first_row_reg = fr[FR_W-1:0];
  endtask

  // One whole source frame at the current size
  task automatic send_frame(input pix_pattern_t pat);
    int unsigned cols, rows;
    logic [PIX_W-1:0] p;
    cols = 2 * eff_width();
    rows = 2 * eff_height();
    for (int unsigned y = 0; y < rows; y++) begin
      for (int unsigned x = 0; x < cols; x++) begin
        case (pat)
          PAT_WHITE:   p = '1;
          PAT_BLACK:   p = '0;
          PAT_CHECKER: p = ((x ^ y) & 1) ? '1 : '0;
          PAT_RAMP:    p = PIX_W'(x + 7 * y);
          default:     p = PIX_W'($urandom_range(0, 255));
        endcase
        send_pixel(p);
      end
    end
  endtask

  // Smallest frame with a filtered row: edges, first row zero, last row, frame end
  task automatic test_small_frame_edges();
    gap_max   = 13;
    stall_max = 13;
    set_frame(CFG_DATA_W'(2), CFG_DATA_W'(3), CFG_DATA_W'(0));
    send_frame(PAT_CHECKER);
  endtask

  // Sizes below the minimum clamp to 2
  task automatic test_size_clamp();
    set_frame(CFG_DATA_W'(0), CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_frame(PAT_RANDOM);
  endtask

  // First row past the end: only the last row comes out
  task automatic test_first_row_past_end();
    set_frame(CFG_DATA_W'(3), CFG_DATA_W'(4), 11'h3FF);
    send_frame(PAT_RANDOM);
  endtask

  // Wide frame, back to back on both sides
  task automatic test_wide_frame();
    gap_max   = 0;
    stall_max = 0;
    set_frame(CFG_DATA_W'(40), CFG_DATA_W'(3), CFG_DATA_W'(1));
    send_frame(PAT_RAMP);
  endtask

  // Tall frame, every filtered row emitted
  task automatic test_tall_frame();
    gap_max   = 0;
    stall_max = 0;
    set_frame(CFG_DATA_W'(2), CFG_DATA_W'(40), CFG_DATA_W'(1));
    send_frame(PAT_RANDOM);
  endtask

  // Random small frames with random settings, content and idling
  task automatic test_random_frames();
    int unsigned start, w, h, hh, fr, pick;
    pix_pattern_t pat;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 19);
      w = (pick == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      pick = $urandom_range(0, 19);
      h = (pick == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      hh = (h < 2) ? 2 : h;
      case ($urandom_range(0, 9))
        0:       fr = 0;
        1:       fr = $urandom_range(hh - 1, 1023);
        2:       fr = 1024 | $urandom_range(1, hh - 1);  // bit 10 is not stored
        default: fr = $urandom_range(1, hh - 1);
      endcase
      case ($urandom_range(0, 9))
        0:       pat = PAT_WHITE;
        1:       pat = PAT_BLACK;
        2:       pat = PAT_CHECKER;
        3:       pat = PAT_RAMP;
        default: pat = PAT_RANDOM;
      endcase
      set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(fr));
      case ($urandom_range(0, 9))
        0: begin
          gap_max   = 0;
          stall_max = 0;
        end
        1: begin
          gap_max   = 0;
          stall_max = 13;
        end
        2: begin
          gap_max   = 13;
          stall_max = 0;
        end
        default: begin
          gap_max   = 13;
          stall_max = 13;
        end
      endcase
      send_frame(pat);
    end
  endtask

  // Main sequence
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_small_frame_edges();
    test_size_clamp();
    test_first_row_past_end();
    test_wide_frame();
    test_tall_frame();
    test_random_frames();
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[gaussian_pyramid_downsample] OK");
    end else begin
      $display("[gaussian_pyramid_downsample] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[gaussian_pyramid_downsample] ERROR");
    $finish;
  end

  // Output side backpressure: stall count drawn per accepted result
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input int unsigned want, got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Compare each output transaction with the oldest queued pixel
  always @(posedge clk) begin
    pyr_px_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pyramid_px_q.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pyramid_px_q.pop_front();
        check_field("value", 32'(want.value), 32'(m_axis_tdata[PIX_W-1:0]));
        check_field("out_col", 32'(want.col), 32'(m_axis_tdata[COL_LO +: COL_W]));
        check_field("out_row", 32'(want.row), 32'(m_axis_tdata[ROW_LO +: ROW_W]));
        check_field("tdata pad", 0, 32'(m_axis_tdata[OUT_TDATA_W-1:PAD_LO]));
        check_field("frame_end", 32'(want.frame_end), 32'(m_axis_tlast));
      end
      stall_left = $urandom_range(0, stall_max);
    end
  end

endmodule
